>>> rtl/assert_macros.svh
// Assertion macros shared by the timer queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SDTQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define SDTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sdtq_pkg.sv
// Shared constants, codes and control/status types for the timer queue
package sdtq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int REQ_W  = 2;
  localparam int TID_W  = 4;
  localparam int TIME_W = 32;
  localparam int ST_W   = 3;
  localparam int MODE_W = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADJUST = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
  localparam logic [ST_W-1:0] ST_ABSENT  = 3'd1;
  localparam logic [ST_W-1:0] ST_USED    = 3'd2;
  localparam logic [ST_W-1:0] ST_EXPIRED = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE    = 3'd4;

  // Streaming pass over the ordered list
  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNLINK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COMPACT = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              load;
    logic [MODE_W-1:0] mode;
    logic              unlink_start;
    logic              link_start;
    logic              link_fin;
    logic              cnt_dec;
    logic              use_set;
    logic              use_clr;
    logic              tick_start;
    logic              rd_issue;
    logic              pop;
    logic              comp_start;
    logic              comp_fin;
    logic              emit;
    logic [ST_W-1:0]   emit_status;
    logic              emit_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_tick;
    logic is_add;
    logic is_delete;
    logic id_ok;
    logic id_used;
    logic full;
    logic stream_done;
    logic scan_more;
    logic expire;
    logic pend;
    logic popped;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: controller, datapath and checks
//
//   channel   direction   handshake            payload
//   in_       request in  in_valid / in_stall  req_type, timer_id, deadline, now_time
//   out_      result out  out_valid / out_stall status, expired_id, last
//
// One request at a time: a delete unlinks, an add links, an adjust unlinks then links;
// a tick pops the expired head entries, then compacts the list to close the gap.
// Reset (rst_n low, synchronous) empties the queue and frees every slot.
// A stalled result holds the sequencer; the next request is taken only after
// the last result of the current one is in the result register.
module sorted_deadline_timer_queue #(
  parameter int DEPTH = sdtq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sdtq_pkg::REQ_W-1:0]  in_req_type,
  input  logic [sdtq_pkg::TID_W-1:0]  in_timer_id,
  input  logic [sdtq_pkg::TIME_W-1:0] in_deadline,
  input  logic [sdtq_pkg::TIME_W-1:0] in_now_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sdtq_pkg::ST_W-1:0]   out_status,
  output logic [sdtq_pkg::TID_W-1:0]  out_expired_id,
  output logic                        out_last
);
  import sdtq_pkg::*;

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  sdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdtq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_timer_id    (in_timer_id),
    .in_deadline    (in_deadline),
    .in_now_time    (in_now_time),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_expired_id (out_expired_id),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

  // A result is only written into a free result register
  `SDTQ_ASSERT_IMPL(a_emit_free, cmd.emit, sts.out_free, "result written over a waiting result")
  // Linking never starts on a full list
  `SDTQ_ASSERT_IMPL(a_link_room, cmd.link_start, !sts.full, "link started on a full list")
  // Once a request is taken the sequencer is busy with it
  `SDTQ_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request not held off")

endmodule

>>> rtl/sdtq_dpath.sv
// Datapath: request registers, ordered list memory, slot flags and result register
module sdtq_dpath #(
  parameter int DEPTH = sdtq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sdtq_pkg::REQ_W-1:0]  in_req_type,
  input  logic [sdtq_pkg::TID_W-1:0]  in_timer_id,
  input  logic [sdtq_pkg::TIME_W-1:0] in_deadline,
  input  logic [sdtq_pkg::TIME_W-1:0] in_now_time,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [sdtq_pkg::ST_W-1:0]   out_status,
  output logic [sdtq_pkg::TID_W-1:0]  out_expired_id,
  output logic                        out_last,
  input  sdtq_pkg::cmd_t              cmd,
  output sdtq_pkg::sts_t              sts
);
  import sdtq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Captured request
  logic [REQ_W-1:0]  req_type_r;
  logic [TID_W-1:0]  req_id_r;
  logic [TIME_W-1:0] req_dl_r;
  logic [TIME_W-1:0] req_now_r;

  // List bookkeeping
  logic [DEPTH-1:0]  in_use_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     ptr_r;
  logic [CW-1:0]     pop_r;
  logic              hit_r;

  // Registered read port
  logic              rd_vld_r;
  logic [AW-1:0]     rd_id_r;
  logic [TIME_W-1:0] rd_dl_r;
  logic [CW-1:0]     rd_tag_r;

  // Pending expired id, held until we know whether it is the last
  logic              pend_r;
  logic [AW-1:0]     pend_id_r;

  // Result register
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [TID_W-1:0]  out_id_r;
  logic              out_last_r;

  // Ordered list storage: id and deadline per position
  logic [AW-1:0]     mem_id [DEPTH];
  logic [TIME_W-1:0] mem_dl [DEPTH];

  logic [AW-1:0]     idx;
  logic              issue;
  logic              rd_en;
  logic [CW-1:0]     rd_ptr;
  logic [AW-1:0]     rd_addr;
  logic              rd_later;
  logic              wr_en;
  logic [CW-1:0]     wr_pos;
  logic [AW-1:0]     wr_id;
  logic [TIME_W-1:0] wr_dl;
  logic              hit_nxt;

  assign idx      = AW'(req_id_r);
  assign rd_later = rd_dl_r > req_dl_r;

  // Read issue for the streaming passes
  always_comb begin
    case (cmd.mode)
      MODE_UNLINK:  issue = ptr_r < cnt_r;
      MODE_COMPACT: issue = ptr_r < cnt_r;
      MODE_LINK:    issue = (ptr_r != '0) && !hit_r;
      default:      issue = 1'b0;
    endcase
  end

  assign rd_en   = issue | cmd.rd_issue;
  assign rd_ptr  = (cmd.mode == MODE_LINK) ? ptr_r - CW'(1) : ptr_r;
  assign rd_addr = rd_ptr[AW-1:0];

  // Single write port: shifted entries or the newly linked timer
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = '0;
    wr_id   = idx;
    wr_dl   = req_dl_r;
    hit_nxt = hit_r;
    if (rd_vld_r) begin
      case (cmd.mode)
        MODE_UNLINK: begin
          if (hit_r) begin
            wr_en  = 1'b1;
            wr_pos = rd_tag_r - CW'(1);
            wr_id  = rd_id_r;
            wr_dl  = rd_dl_r;
          end else if (rd_id_r == idx) begin
            hit_nxt = 1'b1;
          end
        end
        MODE_LINK: begin
          if (!hit_r) begin
            wr_en  = 1'b1;
            wr_pos = rd_tag_r + CW'(1);
            if (rd_later) begin
              wr_id = rd_id_r;
              wr_dl = rd_dl_r;
            end else begin
              hit_nxt = 1'b1;
            end
          end
        end
        MODE_COMPACT: begin
          wr_en  = 1'b1;
          wr_pos = rd_tag_r - pop_r;
          wr_id  = rd_id_r;
          wr_dl  = rd_dl_r;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    // No entry at or before the new timer's deadline was found: it goes to the head
    if (cmd.link_fin && !hit_r) begin
      wr_en  = 1'b1;
      wr_pos = '0;
    end
    // A new pass starts with no match
    if (cmd.unlink_start || cmd.tick_start || cmd.link_start) begin
      hit_nxt = 1'b0;
    end
  end

  // List memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_pos[AW-1:0]] <= wr_id;
      mem_dl[wr_pos[AW-1:0]] <= wr_dl;
    end
    if (rd_en) begin
      rd_id_r  <= mem_id[rd_addr];
      rd_dl_r  <= mem_dl[rd_addr];
      rd_tag_r <= rd_ptr;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      req_id_r   <= in_timer_id;
      req_dl_r   <= in_deadline;
      req_now_r  <= in_now_time;
    end
    if (cmd.pop) begin
      pend_id_r <= rd_id_r;
    end
    if (cmd.comp_start) begin
      pop_r <= ptr_r;
    end
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      cnt_r    <= '0;
      ptr_r    <= '0;
      hit_r    <= 1'b0;
      rd_vld_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      hit_r    <= hit_nxt;

      if (cmd.unlink_start || cmd.tick_start) begin
        ptr_r <= '0;
      end else if (cmd.link_start) begin
        ptr_r <= cnt_r;
      end else if (issue && (cmd.mode == MODE_LINK)) begin
        ptr_r <= ptr_r - CW'(1);
      end else if (issue || cmd.pop) begin
        ptr_r <= ptr_r + CW'(1);
      end

      if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (cmd.link_fin) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.comp_fin) begin
        cnt_r <= cnt_r - pop_r;
      end

      if (cmd.use_set) begin
        in_use_r[idx] <= 1'b1;
      end else if (cmd.use_clr) begin
        in_use_r[idx] <= 1'b0;
      end else if (cmd.pop) begin
        in_use_r[rd_id_r] <= 1'b0;
      end

      if (cmd.tick_start) begin
        pend_r <= 1'b0;
      end else if (cmd.pop) begin
        pend_r <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_id_r     <= (cmd.emit_status == ST_EXPIRED) ? TID_W'(pend_id_r) : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

  // Status back to the controller
  always_comb begin
    sts.is_tick     = req_type_r == REQ_TICK;
    sts.is_add      = req_type_r == REQ_ADD;
    sts.is_delete   = req_type_r == REQ_DELETE;
    sts.id_ok       = 32'(req_id_r) < 32'(DEPTH);
    sts.id_used     = in_use_r[idx];
    sts.full        = cnt_r == CW'(DEPTH);
    sts.stream_done = !issue && !rd_vld_r;
    sts.scan_more   = ptr_r < cnt_r;
    sts.expire      = rd_dl_r <= req_now_r;
    sts.pend        = pend_r;
    sts.popped      = ptr_r != '0;
    sts.out_free    = !out_valid_r || !out_stall;
  end

endmodule

>>> rtl/sdtq_ctrl.sv
// Controller: sequences the list passes for each request and the result emission
module sdtq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sdtq_pkg::sts_t sts,
  output sdtq_pkg::cmd_t cmd
);
  import sdtq_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_UNLINK    = 4'd2;
  localparam logic [3:0] S_LINK_INIT = 4'd3;
  localparam logic [3:0] S_LINK      = 4'd4;
  localparam logic [3:0] S_RESP      = 4'd5;
  localparam logic [3:0] S_T_RD      = 4'd6;
  localparam logic [3:0] S_T_EV      = 4'd7;
  localparam logic [3:0] S_T_END     = 4'd8;
  localparam logic [3:0] S_COMPACT   = 4'd9;

  logic [3:0]      state_r, state_nxt;
  logic [ST_W-1:0] resp_r, resp_nxt;

  assign in_stall = state_r != S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_tick) begin
          cmd.tick_start = 1'b1;
          state_nxt      = S_T_RD;
        end else if (!sts.id_ok) begin
          resp_nxt  = ST_ABSENT;
          state_nxt = S_RESP;
        end else if (sts.is_add) begin
          if (sts.id_used) begin
            resp_nxt  = ST_USED;
            state_nxt = S_RESP;
          end else begin
            cmd.use_set = 1'b1;
            state_nxt   = S_LINK_INIT;
          end
        end else if (!sts.id_used) begin
          resp_nxt  = ST_ABSENT;
          state_nxt = S_RESP;
        end else begin
          cmd.unlink_start = 1'b1;
          cmd.use_clr      = sts.is_delete;
          state_nxt        = S_UNLINK;
        end
      end
      S_UNLINK: begin
        cmd.mode = MODE_UNLINK;
        if (sts.stream_done) begin
          cmd.cnt_dec = 1'b1;
          if (sts.is_delete) begin
            resp_nxt  = ST_DONE;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_LINK_INIT;
          end
        end
      end
      S_LINK_INIT: begin
        cmd.link_start = 1'b1;
        state_nxt      = S_LINK;
      end
      S_LINK: begin
        cmd.mode = MODE_LINK;
        if (sts.stream_done) begin
          cmd.link_fin = 1'b1;
          resp_nxt     = ST_DONE;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = resp_r;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      // Tick: look at the head entries one at a time
      S_T_RD: begin
        if (sts.scan_more) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_T_EV;
        end else begin
          state_nxt = S_T_END;
        end
      end
      S_T_EV: begin
        if (sts.expire) begin
          if (!sts.pend || sts.out_free) begin
            cmd.emit        = sts.pend;
            cmd.emit_status = ST_EXPIRED;
            cmd.pop         = 1'b1;
            state_nxt       = S_T_RD;
          end
        end else begin
          state_nxt = S_T_END;
        end
      end
      S_T_END: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = sts.pend ? ST_EXPIRED : ST_NONE;
          cmd.emit_last   = 1'b1;
          if (sts.popped) begin
            cmd.comp_start = 1'b1;
            state_nxt      = S_COMPACT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_COMPACT: begin
        cmd.mode = MODE_COMPACT;
        if (sts.stream_done) begin
          cmd.comp_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

>>> verif/sorted_deadline_timer_queue_tb.sv
// Self-checking testbench for the sorted deadline timer queue
module sorted_deadline_timer_queue_tb;
  import sdtq_pkg::*;

  localparam int SLOTS          = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [TID_W-1:0]  id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
  } timer_request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [TID_W-1:0] id;
    logic             last;
  } timer_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  // Mirror of the timer list: ordered ids, slot deadlines and the results still owed
  class timer_queue_mirror;
    logic [TID_W-1:0]  queue_order[$];
    logic [TIME_W-1:0] slot_deadline[SLOTS];
    bit                slot_busy[SLOTS];
    timer_result_t     awaited_results[$];
    int                errors;

    function new();
      errors = 0;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    endfunction

    // place after every entry whose deadline is not later
    function void insert_sorted(logic [TID_W-1:0] id);
      int pos;
      pos = 0;
      while (pos < queue_order.size() && slot_deadline[queue_order[pos]] <= slot_deadline[id])
        pos++;
      queue_order.insert(pos, id);
    endfunction

    function void unlink(logic [TID_W-1:0] id);
      for (int i = 0; i < queue_order.size(); i++) begin
        if (queue_order[i] == id) begin
          queue_order.delete(i);
          return;
        end
      end
    endfunction

    function void owe(logic [ST_W-1:0] status, logic [TID_W-1:0] id, logic last);
      timer_result_t r;
      r.status = status;
      r.id     = id;
      r.last   = last;
      awaited_results.push_back(r);
    endfunction

    // work out the results of one accepted request
    function void note_request(timer_request_t req);
      int popped;
      logic [TID_W-1:0] head;
      popped = 0;
      case (req.kind)
        REQ_TICK: begin
          while (queue_order.size() > 0 && popped < SLOTS &&
                 slot_deadline[queue_order[0]] <= req.now) begin
            head = queue_order.pop_front();
            slot_busy[head] = 1'b0;
            owe(ST_EXPIRED, head, 1'b0);
            popped++;
          end
          if (popped == 0)
            owe(ST_NONE, '0, 1'b1);
          else
            awaited_results[awaited_results.size()-1].last = 1'b1;
        end
        REQ_ADD: begin
          if (slot_busy[req.id]) begin
            owe(ST_USED, '0, 1'b1);
          end else begin
            slot_deadline[req.id] = req.deadline;
            slot_busy[req.id]     = 1'b1;
            insert_sorted(req.id);
            owe(ST_DONE, '0, 1'b1);
          end
        end
        default: begin
          if (!slot_busy[req.id]) begin
            owe(ST_ABSENT, '0, 1'b1);
          end else begin
            unlink(req.id);
            if (req.kind == REQ_ADJUST) begin
              slot_deadline[req.id] = req.deadline;
              insert_sorted(req.id);
            end else begin
              slot_busy[req.id] = 1'b0;
            end
            owe(ST_DONE, '0, 1'b1);
          end
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    // compare one accepted result with the oldest one owed
    task check_result(timer_result_t got);
      timer_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d id %0d last %0d",
                                  got.status, got.id, got.last));
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.id !== want.id)
        report_mismatch($sformatf("expired_id %0d, want %0d", got.id, want.id));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  in_req_type    = REQ_TICK;
  logic [TID_W-1:0]  in_timer_id    = '0;
  logic [TIME_W-1:0] in_deadline    = '0;
  logic [TIME_W-1:0] in_now_time    = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [ST_W-1:0]   out_status;
  logic [TID_W-1:0]  out_expired_id;
  logic              out_last;

  timer_queue_mirror book = new();
  logic [TIME_W-1:0] wall_time = '0;
  bit                fill_mode = 1'b0;
  int                stall_phase_left = 0;
  stall_mode_t       stall_mode = STALL_NONE;

  sorted_deadline_timer_queue uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_timer_id    (in_timer_id),
    .in_deadline    (in_deadline),
    .in_now_time    (in_now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_expired_id (out_expired_id),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall in phases of no, light and heavy back-pressure
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_phase_left = $urandom_range(20, 200);
      stall_mode       = stall_mode_t'($urandom_range(0, 2));
    end else begin
      stall_phase_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_result(timer_result_t'{out_status, out_expired_id, out_last});
  end

  // Watchdog: ends the run after a long stretch with no request or result moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("sorted_deadline_timer_queue_tb: done, errors");
    $finish;
  end

  // Present one request and hold it until accepted
  task automatic send_request(timer_request_t req);
    in_req_type <= req.kind;
    in_timer_id <= req.id;
    in_deadline <= req.deadline;
    in_now_time <= req.now;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(req);
  endtask

  task automatic send_fields(logic [REQ_W-1:0] kind, logic [TID_W-1:0] id,
                             logic [TIME_W-1:0] deadline, logic [TIME_W-1:0] now);
    timer_request_t req;
    req.kind     = kind;
    req.id       = id;
    req.deadline = deadline;
    req.now      = now;
    send_request(req);
  endtask

  // only called with a non-zero count, so valid is never lowered and raised in one step
  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // random slot that is busy or free as asked; fallback when there is none
  function automatic logic [TID_W-1:0] pick_slot(bit busy, logic [TID_W-1:0] fallback);
    int start;
    start = $urandom_range(0, SLOTS-1);
    for (int k = 0; k < SLOTS; k++)
      if (book.slot_busy[(start + k) % SLOTS] == busy)
        return TID_W'((start + k) % SLOTS);
    return fallback;
  endfunction

  // mostly just ahead of the wall clock, sometimes anywhere or tied with a queued timer
  function automatic logic [TIME_W-1:0] near_deadline();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return $urandom;
    if (pick == 1 && book.queue_order.size() > 0)
      return book.slot_deadline[book.queue_order[$urandom_range(0, book.queue_order.size()-1)]];
    return wall_time + $urandom_range(0, 150);
  endfunction

  function automatic timer_request_t next_random_request();
    timer_request_t req;
    int pick;
    req.kind     = REQ_TICK;
    req.id       = TID_W'($urandom);
    req.deadline = $urandom;
    req.now      = $urandom;
    pick         = $urandom_range(0, 99);
    if (pick >= 97)
      fill_mode = 1'b1;
    if (fill_mode) begin
      // fill every slot, then send one tick that drains some or all of them
      if (book.queue_order.size() < SLOTS) begin
        req.kind     = REQ_ADD;
        req.id       = pick_slot(1'b0, req.id);
        req.deadline = near_deadline();
      end else begin
        req.now   = (pick < 50) ? '1 : wall_time + 200;
        fill_mode = 1'b0;
      end
    end else if (pick < 35) begin
      req.kind     = REQ_ADD;
      req.id       = (pick < 30) ? pick_slot(1'b0, req.id) : req.id;
      req.deadline = near_deadline();
    end else if (pick < 50) begin
      req.kind     = REQ_ADJUST;
      req.id       = (pick < 47) ? pick_slot(1'b1, req.id) : req.id;
      req.deadline = near_deadline();
    end else if (pick < 60) begin
      req.kind = REQ_DELETE;
      req.id   = (pick < 58) ? pick_slot(1'b1, req.id) : req.id;
    end else if ($urandom_range(0, 9) == 0) begin
      // tick at an arbitrary time; sometimes the clock jumps there
      if ($urandom_range(0, 2) == 0)
        wall_time = req.now;
    end else begin
      wall_time = wall_time + $urandom_range(0, 40);
      req.now   = wall_time;
    end
    return req;
  endfunction

  initial begin
    int burst_left;
    int gap;
    int sent;
    logic [TIME_W-1:0] dl;
    burst_left = 0;
    sent       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: nothing expires, nothing to adjust or delete
    send_fields(REQ_TICK, 4'd0, '0, '0);
    send_fields(REQ_DELETE, 4'd0, '0, '1);
    send_fields(REQ_ADJUST, 4'd15, '1, '0);

    // fill every slot, with ties to check first-in first-out order
    for (int i = 0; i < SLOTS; i++) begin
      if (i == 0)
        dl = '0;
      else if (i <= 6)
        dl = 32'd500;
      else if (i <= 9)
        dl = 32'h8000_0000;
      else if (i <= 13)
        dl = 32'h1234 * i;
      else
        dl = '1;
      send_fields(REQ_ADD, TID_W'(i), dl, 32'h5555_5555);
    end
    send_fields(REQ_ADD, 4'd3, 32'd1, '0);            // slot already in use
    send_fields(REQ_ADJUST, 4'd15, '0, '0);           // earlier, ties with the head
    send_fields(REQ_ADJUST, 4'd4, 32'h7FFF_FFFF, '0); // later
    send_fields(REQ_TICK, 4'd0, '0, '1);              // pops all sixteen

    // deadline equal to the current time expires
    send_fields(REQ_ADD, 4'd3, 32'd7, '0);
    send_fields(REQ_TICK, 4'd0, '0, 32'd6);
    send_fields(REQ_TICK, 4'd0, '0, 32'd7);

    // random part in bursts with gaps
    wall_time = $urandom_range(0, 1000);
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0)
          pause_sender(gap);
      end
      send_request(next_random_request());
      burst_left--;
      sent++;
    end
    pause_sender(1);

    // drain, then leave room for anything stray
    while (book.awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0)
      $display("sorted_deadline_timer_queue_tb: done, clean");
    else
      $display("sorted_deadline_timer_queue_tb: done, errors");
    $finish;
  end

endmodule
